>>> rtl/core/vpsvc_pkg.sv
// Shared types, codes and sizes for the view pair shared visibility counter.
`timescale 1ns / 1ps

package vpsvc_pkg;

   // Store geometry: one row of word-packed bits per view
   localparam int VIEW_W      = 6;
   localparam int WORD_W      = 6;
   localparam int ADDR_W      = VIEW_W + WORD_W;
   localparam int DATA_W      = 64;
   localparam int BIT_W       = 6;
   localparam int POINT_W     = WORD_W + BIT_W;
   localparam int DEPTH       = 1 << ADDR_W;
   localparam int PCNT_W      = BIT_W + 1;

   // Configuration and result widths
   localparam int VCOUNT_W    = 7;
   localparam int PCOUNT_W    = 13;
   localparam int TOTAL_W     = 13;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int PADDR_W     = 3;
   localparam int PDATA_W     = 32;

   localparam logic [VCOUNT_W-1:0] MAX_VIEWS   = VCOUNT_W'(1 << VIEW_W);
   localparam logic [PCOUNT_W-1:0] MAX_POINTS  = PCOUNT_W'(1 << POINT_W);

   // Commands
   localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_VIEW_RANGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_POINT_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_SAME_VIEW   = 2'd3;

   // Register indexes
   localparam logic REG_VIEW_COUNT  = 1'b0;
   localparam logic REG_POINT_COUNT = 1'b1;

   typedef struct packed {
      logic [VCOUNT_W-1:0] view_count;
      logic [PCOUNT_W-1:0] point_count;
   } cfg_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } store_rd_type;

endpackage

>>> rtl/core/vpsvc_channels.sv
// Item channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface vpsvc_req_if;
   logic                         valid;
   logic                         ready;
   logic [vpsvc_pkg::CMD_W-1:0]  command;
   logic [vpsvc_pkg::VIEW_W-1:0] view_a;
   logic [vpsvc_pkg::VIEW_W-1:0] view_b;
   logic [vpsvc_pkg::POINT_W-1:0] point_index;

   modport source (output valid, command, view_a, view_b, point_index, input ready);
   modport sink (input valid, command, view_a, view_b, point_index, output ready);
endinterface

interface vpsvc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [vpsvc_pkg::TOTAL_W-1:0]  shared_count;
   logic [vpsvc_pkg::STATUS_W-1:0] status;

   modport source (output valid, shared_count, status, input ready);
   modport sink (input valid, shared_count, status, output ready);
endinterface

>>> rtl/core/vpsvc_csr.sv
// APB-style configuration registers: view count and point count.
`timescale 1ns / 1ps

module vpsvc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [vpsvc_pkg::PADDR_W-1:0]    paddr,
   input  logic [vpsvc_pkg::PDATA_W-1:0]    pwdata,
   output logic [vpsvc_pkg::PDATA_W-1:0]    prdata,
   output logic                             pready,
   output vpsvc_pkg::cfg_type               cfg
);

   logic [vpsvc_pkg::VCOUNT_W-1:0] view_count_ff;
   logic [vpsvc_pkg::PCOUNT_W-1:0] point_count_ff;
   logic                           wr_go;

   assign pready = 1'b1;
   assign wr_go  = psel & penable & pwrite;

   // Write on the access phase; word offset picks the register
   always_ff @(posedge clock) begin
      if (reset) begin
         view_count_ff  <= vpsvc_pkg::MAX_VIEWS;
         point_count_ff <= vpsvc_pkg::MAX_POINTS;
      end else if (wr_go) begin
         if (paddr[2] == vpsvc_pkg::REG_VIEW_COUNT) begin
            view_count_ff <= pwdata[vpsvc_pkg::VCOUNT_W-1:0];
         end else begin
            point_count_ff <= pwdata[vpsvc_pkg::PCOUNT_W-1:0];
         end
      end
   end

   // Read back
   always_comb begin
      if (paddr[2] == vpsvc_pkg::REG_VIEW_COUNT) begin
         prdata = {{(vpsvc_pkg::PDATA_W - vpsvc_pkg::VCOUNT_W){1'b0}}, view_count_ff};
      end else begin
         prdata = {{(vpsvc_pkg::PDATA_W - vpsvc_pkg::PCOUNT_W){1'b0}}, point_count_ff};
      end
   end

   assign cfg.view_count  = view_count_ff;
   assign cfg.point_count = point_count_ff;

endmodule

>>> rtl/core/vpsvc_store.sv
// Visibility word store: one write port, two read ports, registered read data.
`timescale 1ns / 1ps

module vpsvc_store (
   input  logic                              clock,
   input  vpsvc_pkg::store_wr_type           wr,
   input  vpsvc_pkg::store_rd_type           rd,
   output logic [vpsvc_pkg::DATA_W-1:0]      rd_data_a,
   output logic [vpsvc_pkg::DATA_W-1:0]      rd_data_b
);

   logic [vpsvc_pkg::DATA_W-1:0] mem [vpsvc_pkg::DEPTH];
   logic [vpsvc_pkg::DATA_W-1:0] rd_data_a_ff;
   logic [vpsvc_pkg::DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_a_ff <= mem[rd.addr_a];
         rd_data_b_ff <= mem[rd.addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> rtl/core/vpsvc_tally.sv
// Masked AND-popcount stage and running total for a pair count.
`timescale 1ns / 1ps

module vpsvc_tally (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic                              in_valid,
   input  logic [vpsvc_pkg::DATA_W-1:0]      word_a,
   input  logic [vpsvc_pkg::DATA_W-1:0]      word_b,
   input  logic [vpsvc_pkg::WORD_W-1:0]      word_idx,
   input  logic [vpsvc_pkg::PCOUNT_W-1:0]    plim,
   output logic                              busy,
   output logic [vpsvc_pkg::TOTAL_W-1:0]     total
);

   logic [vpsvc_pkg::DATA_W-1:0]   mask;
   logic [vpsvc_pkg::DATA_W-1:0]   masked;
   logic [vpsvc_pkg::WORD_W:0]     plim_word;
   logic [vpsvc_pkg::PCNT_W-1:0]   pc_in;
   logic [vpsvc_pkg::PCNT_W-1:0]   pc_ff;
   logic                           pc_vld_ff;
   logic [vpsvc_pkg::TOTAL_W-1:0]  acc_ff;

   // Bit count by folding fields, no carry chain longer than a byte
   function automatic logic [vpsvc_pkg::PCNT_W-1:0] bit_total(
      input logic [vpsvc_pkg::DATA_W-1:0] x
   );
      logic [vpsvc_pkg::DATA_W-1:0] s1;
      logic [vpsvc_pkg::DATA_W-1:0] s2;
      logic [vpsvc_pkg::DATA_W-1:0] s3;
      logic [vpsvc_pkg::DATA_W-1:0] s4;
      logic [vpsvc_pkg::DATA_W-1:0] s5;
      logic [vpsvc_pkg::DATA_W-1:0] s6;
      s1 = x - ((x >> 1) & 64'h5555_5555_5555_5555);
      s2 = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
      s3 = (s2 + (s2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
      s4 = s3 + (s3 >> 8);
      s5 = s4 + (s4 >> 16);
      s6 = s5 + (s5 >> 32);
      return s6[vpsvc_pkg::PCNT_W-1:0];
   endfunction

   // Keep only points below the limit within this word
   assign plim_word = plim[vpsvc_pkg::PCOUNT_W-1:vpsvc_pkg::BIT_W];
   always_comb begin
      if ({1'b0, word_idx} < plim_word) begin
         mask = '1;
      end else if ({1'b0, word_idx} == plim_word) begin
         mask = ~({vpsvc_pkg::DATA_W{1'b1}} << plim[vpsvc_pkg::BIT_W-1:0]);
      end else begin
         mask = '0;
      end
   end

   assign masked = word_a & word_b & mask;
   assign pc_in  = bit_total(masked);

   // Count stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_vld_ff <= 1'b0;
      end else begin
         pc_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff <= pc_in;
   end

   // Accumulate
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         acc_ff <= '0;
      end else if (pc_vld_ff) begin
         acc_ff <= acc_ff + {{(vpsvc_pkg::TOTAL_W - vpsvc_pkg::PCNT_W){1'b0}}, pc_ff};
      end
   end

   assign busy  = in_valid | pc_vld_ff;
   assign total = acc_ff;

endmodule

>>> rtl/core/view_pair_shared_visibility_counter.sv
// Top level: request sequencer around the visibility store and count pipeline.
`timescale 1ns / 1ps

// Usage
//   req_chan takes one item per command (mark, count pair, clear); rsp_chan gives one
//   item back per request, in order, with shared_count and status. An item moves on
//   a channel when valid and ready are both high at a rising clock edge.
//   The APB port sets view_count (offset 0) and point_count (offset 4); write it only
//   while no request is in flight.
// Sequence, one item at a time:
//   error or unused command: straight to the response register; mark: read, modify,
//   write back; count: walks the 64 word pairs of the two view rows through the
//   store's two read ports, one pair per cycle, then drains the count pipeline;
//   clear: all 4096 store words zeroed, one word per cycle.
// Overlap: the next request is taken at the edge where the previous response can
//   leave, so the block never takes a new item before the last one is done.
// Reset: the store is swept to zero, during which req_chan.ready stays low; the
//   registers return to 64 views and 4096 points at once.
// Stall: a finished response waits in an output register; the next request is
//   taken meanwhile, and its own response waits until that register drains.

module view_pair_shared_visibility_counter (
   input  logic                             clock,
   input  logic                             reset,
   vpsvc_req_if.sink                        req_chan,
   vpsvc_rsp_if.source                      rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [vpsvc_pkg::PADDR_W-1:0]    paddr,
   input  logic [vpsvc_pkg::PDATA_W-1:0]    pwdata,
   output logic [vpsvc_pkg::PDATA_W-1:0]    prdata,
   output logic                             pready
);

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_COUNT,
      ST_DRAIN,
      ST_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [vpsvc_pkg::CMD_W-1:0]       cmd_ff, cmd_in;
   logic [vpsvc_pkg::VIEW_W-1:0]      va_ff, va_in;
   logic [vpsvc_pkg::VIEW_W-1:0]      vb_ff, vb_in;
   logic [vpsvc_pkg::POINT_W-1:0]     pt_ff, pt_in;
   logic [vpsvc_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [vpsvc_pkg::WORD_W-1:0]      word_ff, word_in;
   logic [vpsvc_pkg::ADDR_W-1:0]      wipe_ff, wipe_in;
   logic                              owe_ff, owe_in;
   logic                              rd_vld_ff;
   logic [vpsvc_pkg::WORD_W-1:0]      rd_word_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [vpsvc_pkg::TOTAL_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [vpsvc_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   vpsvc_pkg::cfg_type                cfg;
   vpsvc_pkg::store_wr_type           st_wr;
   vpsvc_pkg::store_rd_type           st_rd;
   logic [vpsvc_pkg::DATA_W-1:0]      rd_data_a;
   logic [vpsvc_pkg::DATA_W-1:0]      rd_data_b;
   logic [vpsvc_pkg::VCOUNT_W-1:0]    vlim;
   logic [vpsvc_pkg::PCOUNT_W-1:0]    plim;
   logic                              take;
   logic                              va_bad;
   logic                              vb_bad;
   logic                              pt_bad;
   logic                              tally_busy;
   logic [vpsvc_pkg::TOTAL_W-1:0]     tally_total;
   logic                              rsp_free;
   logic [vpsvc_pkg::ADDR_W-1:0]      mark_addr;

   vpsvc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Effective limits
   assign vlim = (cfg.view_count < vpsvc_pkg::MAX_VIEWS) ? cfg.view_count
                                                          : vpsvc_pkg::MAX_VIEWS;
   assign plim = (cfg.point_count < vpsvc_pkg::MAX_POINTS) ? cfg.point_count
                                                            : vpsvc_pkg::MAX_POINTS;

   assign take   = (state_ff == ST_IDLE) && req_chan.valid;
   assign va_bad = {1'b0, req_chan.view_a} >= vlim;
   assign vb_bad = {1'b0, req_chan.view_b} >= vlim;
   assign pt_bad = {1'b0, req_chan.point_index} >= plim;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Store access
   assign mark_addr = {va_ff, pt_ff[vpsvc_pkg::POINT_W-1:vpsvc_pkg::BIT_W]};

   always_comb begin
      st_rd.en     = (state_ff == ST_MARK_RD) || (state_ff == ST_COUNT);
      st_rd.addr_a = (state_ff == ST_COUNT) ? {va_ff, word_ff} : mark_addr;
      st_rd.addr_b = {vb_ff, word_ff};
      st_wr.en     = (state_ff == ST_MARK_WR) || (state_ff == ST_WIPE);
      if (state_ff == ST_WIPE) begin
         st_wr.addr = wipe_ff;
         st_wr.data = '0;
      end else begin
         st_wr.addr = mark_addr;
         st_wr.data = rd_data_a |
                      ({{(vpsvc_pkg::DATA_W-1){1'b0}}, 1'b1} <<
                       pt_ff[vpsvc_pkg::BIT_W-1:0]);
      end
   end

   vpsvc_store u_store (
      .clock     (clock),
      .wr        (st_wr),
      .rd        (st_rd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   vpsvc_tally u_tally (
      .clock    (clock),
      .reset    (reset),
      .clear    (take),
      .in_valid (rd_vld_ff),
      .word_a   (rd_data_a),
      .word_b   (rd_data_b),
      .word_idx (rd_word_ff),
      .plim     (plim),
      .busy     (tally_busy),
      .total    (tally_total)
   );

   // Sequencer: next state and response register
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      pt_in         = pt_ff;
      status_in     = status_ff;
      word_in       = word_ff;
      wipe_in       = wipe_ff;
      owe_in        = owe_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_WIPE: begin
            wipe_in = wipe_ff + 1'b1;
            if (&wipe_ff) begin
               owe_in   = 1'b0;
               state_in = owe_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               cmd_in    = req_chan.command;
               va_in     = req_chan.view_a;
               vb_in     = req_chan.view_b;
               pt_in     = req_chan.point_index;
               status_in = vpsvc_pkg::STATUS_OK;
               word_in   = '0;
               state_in  = ST_DONE;
               case (req_chan.command)
                  vpsvc_pkg::CMD_MARK: begin
                     if (va_bad) begin
                        status_in = vpsvc_pkg::STATUS_VIEW_RANGE;
                     end else if (pt_bad) begin
                        status_in = vpsvc_pkg::STATUS_POINT_RANGE;
                     end else begin
                        state_in = ST_MARK_RD;
                     end
                  end
                  vpsvc_pkg::CMD_COUNT: begin
                     if (va_bad || vb_bad) begin
                        status_in = vpsvc_pkg::STATUS_VIEW_RANGE;
                     end else if (req_chan.view_a == req_chan.view_b) begin
                        status_in = vpsvc_pkg::STATUS_SAME_VIEW;
                     end else begin
                        state_in = ST_COUNT;
                     end
                  end
                  vpsvc_pkg::CMD_CLEAR: begin
                     owe_in   = 1'b1;
                     wipe_in  = '0;
                     state_in = ST_WIPE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            state_in = ST_DONE;
         end
         ST_COUNT: begin
            word_in = word_ff + 1'b1;
            if (&word_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !tally_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (cmd_ff == vpsvc_pkg::CMD_COUNT && status_ff == vpsvc_pkg::STATUS_OK) begin
                  rsp_count_in = tally_total;
               end else begin
                  rsp_count_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         wipe_ff      <= '0;
         owe_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wipe_ff      <= wipe_in;
         owe_ff       <= owe_in;
         rd_vld_ff    <= (state_ff == ST_COUNT);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      pt_ff         <= pt_in;
      status_ff     <= status_in;
      word_ff       <= word_in;
      rd_word_ff    <= word_ff;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.shared_count = rsp_count_ff;
   assign rsp_chan.status       = rsp_status_ff;

endmodule

>>> test/tb_top.sv
// Testbench for the view pair shared visibility counter: directed and random items.
`timescale 1ns / 1ps

module tb_top;
   import vpsvc_pkg::*;

   localparam int ROW_BITS           = 1 << POINT_W;
   localparam int VIEW_ROWS          = 1 << VIEW_W;
   localparam int SHARED_MAX         = (1 << TOTAL_W) - 1;
   localparam int RSP_HOLDOFF_CYCLES = 400;
   localparam int SETTLE_CYCLES      = 100;

   typedef struct packed {
      logic [TOTAL_W-1:0]  shared_count;
      logic [STATUS_W-1:0] status;
   } shared_result_type;

   // Predicted visibility rows, register copies and the results still owed by the block
   class shared_visibility_tracker;
      bit [ROW_BITS-1:0]   view_rows [VIEW_ROWS];
      logic [VCOUNT_W-1:0] view_count;
      logic [PCOUNT_W-1:0] point_count;
      shared_result_type   pending_results [$];
      int unsigned         mismatches;
      int unsigned         command_seen [4];
      int unsigned         status_seen [4];
      int unsigned         largest_shared;

      function new();
         foreach (view_rows[v]) view_rows[v] = '0;
         view_count     = MAX_VIEWS;
         point_count    = MAX_POINTS;
         mismatches     = 0;
         largest_shared = 0;
         foreach (command_seen[i]) command_seen[i] = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function int unsigned usable_views();
         return (view_count < VIEW_ROWS) ? view_count : VIEW_ROWS;
      endfunction

      function int unsigned usable_points();
         return (point_count < ROW_BITS) ? point_count : ROW_BITS;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // Keep only the register's own bits
      function void write_register(logic reg_idx, logic [PDATA_W-1:0] value);
         if (reg_idx == REG_VIEW_COUNT) begin
            view_count = value[VCOUNT_W-1:0];
         end else begin
            point_count = value[PCOUNT_W-1:0];
         end
      endfunction

      // Apply an accepted item to the rows and queue the result it owes
      function void note_request(logic [CMD_W-1:0] cmd, logic [VIEW_W-1:0] view_a,
                                 logic [VIEW_W-1:0] view_b, logic [POINT_W-1:0] point);
         shared_result_type res;
         bit [ROW_BITS-1:0] window;
         int unsigned       nviews;
         int unsigned       npoints;
         int unsigned       total;
         nviews           = usable_views();
         npoints          = usable_points();
         res.shared_count = '0;
         res.status       = STATUS_OK;
         command_seen[int'(cmd)]++;
         case (cmd)
            CMD_MARK: begin
               if (view_a >= nviews) begin
                  res.status = STATUS_VIEW_RANGE;
               end else if (point >= npoints) begin
                  res.status = STATUS_POINT_RANGE;
               end else begin
                  view_rows[view_a][point] = 1'b1;
               end
            end
            CMD_COUNT: begin
               if (view_a >= nviews || view_b >= nviews) begin
                  res.status = STATUS_VIEW_RANGE;
               end else if (view_a == view_b) begin
                  res.status = STATUS_SAME_VIEW;
               end else begin
                  // Count only points below the current point limit
                  window = '1;
                  window = window >> (ROW_BITS - npoints);
                  total  = $countones(view_rows[view_a] & view_rows[view_b] & window);
                  if (total > SHARED_MAX) total = SHARED_MAX;
                  res.shared_count = TOTAL_W'(total);
               end
            end
            CMD_CLEAR: begin
               foreach (view_rows[v]) view_rows[v] = '0;
            end
            default: begin
            end
         endcase
         pending_results = {pending_results, res};
      endfunction

      // Compare one accepted result with the oldest one owed
      function void check_response(logic [TOTAL_W-1:0] got_count,
                                   logic [STATUS_W-1:0] got_status);
         shared_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with none owed: shared_count %0d status %0d",
                     $time, got_count, got_status);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         status_seen[int'(want.status)]++;
         if (want.shared_count > largest_shared) largest_shared = want.shared_count;
         if (got_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got_status);
            mismatches++;
         end
         if (got_count !== want.shared_count) begin
            $display("%0t: shared_count mismatch: expected %0d, actual %0d",
                     $time, want.shared_count, got_count);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   bit quiet_tail  = 1'b0;
   bit rsp_holdoff = 1'b0;

   shared_visibility_tracker tracker = new();

   vpsvc_req_if req_chan ();
   vpsvc_rsp_if rsp_chan ();

   view_pair_shared_visibility_counter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #5 clock = ~clock;

   // End the run with FAIL if it hangs
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         tracker.check_response(rsp_chan.shared_count, rsp_chan.status);
      end
   end

   // Drive result ready: random bursts, one long hold-off on request, steady at the tail
   initial begin : rsp_side
      int unsigned run;
      rsp_chan.ready = 1'b0;
      forever begin
         if (rsp_holdoff) begin
            @(negedge clock);
            rsp_chan.ready = 1'b0;
            repeat (RSP_HOLDOFF_CYCLES) @(negedge clock);
            rsp_holdoff = 1'b0;
         end else if (quiet_tail) begin
            @(negedge clock);
            rsp_chan.ready = 1'b1;
         end else begin
            run = $urandom_range(1, 19);
            @(negedge clock);
            rsp_chan.ready = ($urandom_range(0, 99) < 65);
            repeat (run - 1) @(negedge clock);
         end
      end
   end

   // Offer one item and wait until the block takes it
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VIEW_W-1:0] view_a,
                               input logic [VIEW_W-1:0] view_b,
                               input logic [POINT_W-1:0] point);
      @(negedge clock);
      req_chan.valid       = 1'b1;
      req_chan.command     = cmd;
      req_chan.view_a      = view_a;
      req_chan.view_b      = view_b;
      req_chan.point_index = point;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      tracker.note_request(cmd, view_a, view_b, point);
   endtask

   // Drop valid for the given number of cycles
   task automatic req_pause(input int unsigned cycles);
      @(negedge clock);
      req_chan.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_pause(1);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access cycle
   task automatic csr_access(input logic wr, input logic reg_idx,
                             input logic [PDATA_W-1:0] wdata,
                             output logic [PDATA_W-1:0] rdata);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = wr;
      paddr   = {reg_idx, 2'b00};
      pwdata  = wdata;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      rdata = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // Write a register with junk above its width, then read it back
   task automatic set_register(input logic reg_idx, input int unsigned value);
      logic [PDATA_W-1:0] wdata;
      logic [PDATA_W-1:0] readback;
      logic [PDATA_W-1:0] want;
      wdata = PDATA_W'(value) |
              (PDATA_W'($urandom) << ((reg_idx == REG_VIEW_COUNT) ? VCOUNT_W : PCOUNT_W));
      csr_access(1'b1, reg_idx, wdata, readback);
      tracker.write_register(reg_idx, wdata);
      csr_access(1'b0, reg_idx, '0, readback);
      want = (reg_idx == REG_VIEW_COUNT) ? PDATA_W'(tracker.view_count)
                                         : PDATA_W'(tracker.point_count);
      if (readback !== want) begin
         $display("%0t: register %0d readback mismatch: expected %0d, actual %0d",
                  $time, reg_idx, want, readback);
         tracker.mismatches++;
      end
   endtask

   task automatic reconfigure(input int unsigned views, input int unsigned points);
      wait_for_results();
      set_register(REG_VIEW_COUNT, views);
      set_register(REG_POINT_COUNT, points);
   endtask

   // Mostly a few low views, with edges of the limit and full-range noise
   function automatic logic [VIEW_W-1:0] pick_view(input int unsigned nviews);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (nviews == 0 || roll < 8) return VIEW_W'($urandom);
      if (roll < 12) return VIEW_W'(nviews);
      if (roll < 20) return VIEW_W'(nviews - 1);
      return VIEW_W'($urandom_range(0, ((nviews < 6) ? nviews : 6) - 1));
   endfunction

   // Build one random item; points cluster low so views overlap
   task automatic random_request();
      int unsigned       nviews;
      int unsigned       npoints;
      int unsigned       roll;
      logic [CMD_W-1:0]  cmd;
      logic [VIEW_W-1:0] view_a;
      logic [VIEW_W-1:0] view_b;
      logic [POINT_W-1:0] point;
      nviews  = tracker.usable_views();
      npoints = tracker.usable_points();
      view_a  = pick_view(nviews);
      view_b  = pick_view(nviews);
      roll    = $urandom_range(0, 99);
      if (npoints == 0 || roll < 10) begin
         point = POINT_W'($urandom);
      end else if (roll < 15) begin
         point = POINT_W'(npoints);
      end else if (roll < 20) begin
         point = POINT_W'(npoints - 1);
      end else begin
         point = POINT_W'($urandom_range(0, ((npoints < 256) ? npoints : 256) - 1));
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
         cmd = CMD_MARK;
      end else if (roll < 88) begin
         cmd = CMD_COUNT;
      end else if (roll < 91) begin
         cmd = CMD_NONE;
      end else if (roll < 92) begin
         cmd = CMD_CLEAR;
      end else begin
         cmd    = CMD_COUNT;
         view_b = view_a;
      end
      send_request(cmd, view_a, view_b, point);
   endtask

   // One setting of the registers followed by random items
   task automatic run_phase(input int unsigned items, input int unsigned views,
                            input int unsigned points, input int holdoff_at,
                            input int pause_at);
      reconfigure(views, points);
      for (int i = 0; i < items; i++) begin
         if (i == holdoff_at) rsp_holdoff = 1'b1;
         if (i == pause_at) wait_for_results();
         if (!quiet_tail && !rsp_holdoff && $urandom_range(0, 99) < 25) begin
            req_pause($urandom_range(1, 19));
         end
         random_request();
      end
   endtask

   initial begin
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_MARK;
      req_chan.view_a      = '0;
      req_chan.view_b      = '0;
      req_chan.point_index = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: corners of the rows, every command, each error in check order
      set_register(REG_VIEW_COUNT, 64);
      set_register(REG_POINT_COUNT, 4096);
      send_request(CMD_MARK, 6'd0, 6'd0, 12'd0);
      send_request(CMD_MARK, 6'd1, 6'd0, 12'd0);
      send_request(CMD_MARK, 6'd0, 6'd0, 12'd63);
      send_request(CMD_MARK, 6'd1, 6'd0, 12'd63);
      send_request(CMD_MARK, 6'd0, 6'd0, 12'd64);
      send_request(CMD_MARK, 6'd1, 6'd0, 12'd64);
      send_request(CMD_MARK, 6'd63, 6'd0, 12'd4095);
      send_request(CMD_MARK, 6'd62, 6'd0, 12'd4095);
      send_request(CMD_COUNT, 6'd0, 6'd1, 12'd0);
      send_request(CMD_COUNT, 6'd63, 6'd62, 12'd4095);
      send_request(CMD_COUNT, 6'd1, 6'd0, 12'd0);
      send_request(CMD_COUNT, 6'd7, 6'd7, 12'd0);
      send_request(CMD_NONE, 6'd63, 6'd63, 12'd4095);
      // Lower the point limit: bits above it stay set but drop out of the count
      reconfigure(64, 64);
      send_request(CMD_COUNT, 6'd0, 6'd1, 12'd0);
      send_request(CMD_MARK, 6'd0, 6'd0, 12'd64);
      reconfigure(10, 100);
      send_request(CMD_MARK, 6'd10, 6'd0, 12'd5);
      send_request(CMD_COUNT, 6'd10, 6'd10, 12'd0);
      send_request(CMD_COUNT, 6'd3, 6'd12, 12'd0);
      send_request(CMD_COUNT, 6'd12, 6'd3, 12'd0);
      send_request(CMD_MARK, 6'd9, 6'd0, 12'd99);
      send_request(CMD_MARK, 6'd9, 6'd0, 12'd100);
      send_request(CMD_MARK, 6'd10, 6'd0, 12'd100);
      send_request(CMD_CLEAR, 6'd0, 6'd0, 12'd0);
      send_request(CMD_COUNT, 6'd0, 6'd1, 12'd0);

      // Random phases across register settings, extremes included
      run_phase(170, 127, 8191, -1, -1);
      run_phase(170, 8, 200, 60, -1);
      run_phase(170, 2, 64, -1, 80);
      run_phase(60, 1, 1, -1, -1);
      run_phase(60, 0, 0, -1, -1);
      run_phase(170, 33, 4095, -1, -1);
      run_phase(170, $urandom_range(1, 64), $urandom_range(0, 4096), -1, -1);
      run_phase(170, 64, 4096, -1, -1);
      quiet_tail = 1'b1;
      run_phase(160, 64, 65, -1, -1);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d marks, %0d counts, %0d clears and %0d unused commands.",
               tracker.command_seen[CMD_MARK], tracker.command_seen[CMD_COUNT],
               tracker.command_seen[CMD_CLEAR], tracker.command_seen[CMD_NONE]);
      $display("Results: %0d ok, %0d view range, %0d point range, %0d same view; peak %0d.",
               tracker.status_seen[STATUS_OK], tracker.status_seen[STATUS_VIEW_RANGE],
               tracker.status_seen[STATUS_POINT_RANGE], tracker.status_seen[STATUS_SAME_VIEW],
               tracker.largest_shared);
      if (tracker.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/vpsvc_pkg.sv
rtl/core/vpsvc_channels.sv
rtl/core/vpsvc_csr.sv
rtl/core/vpsvc_store.sv
rtl/core/vpsvc_tally.sv
rtl/core/view_pair_shared_visibility_counter.sv
test/tb_top.sv
